>>> hdl/ldcpm_pkg.sv
// Package for the laser dose curve power map: field widths, fixed-point
// constants, register indexes and the default curve table.
// No dependencies.
`timescale 1ns / 1ps

package ldcpm_pkg;

    localparam int FRACTION_BITS = 16;
    localparam logic [16:0] LIGHT_ONE = 17'h10000;
    localparam int POWER_PERIOD = 127;
    // power quotient bits; the largest density gives a quotient below 256
    localparam int POWER_QW = 8;

    localparam logic [2:0] REG_SPEED_MIN   = 3'd0;
    localparam logic [2:0] REG_SPEED_MAX   = 3'd1;
    localparam logic [2:0] REG_VALUE_MIN   = 3'd2;
    localparam logic [2:0] REG_VALUE_MAX   = 3'd3;
    localparam logic [2:0] REG_GAMMA       = 3'd4;
    localparam logic [2:0] REG_POINT_COUNT = 3'd5;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    localparam logic [10:0] GAMMA_UNITY = 11'd256;

    typedef logic [14:0] point_t;

    function automatic point_t dflt_density(int i);
        point_t v;
        case (i)
            0: v = 15'd2560;
            1: v = 15'd5120;
            2: v = 15'd7680;
            3: v = 15'd11520;
            4: v = 15'd15360;
            5: v = 15'd20480;
            6: v = 15'd25600;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    function automatic point_t dflt_light(int i);
        point_t v;
        case (i)
            0: v = 15'd128;
            1: v = 15'd512;
            2: v = 15'd1792;
            3: v = 15'd5376;
            4: v = 15'd9472;
            5: v = 15'd12800;
            6: v = 15'd25600;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/laser_dose_curve_power_map_core.sv
// Laser dose curve power map core: speed word to 7-bit power byte through
// a gamma rolloff and an inverse dose curve. Depends on ldcpm_pkg.
// Write beats leave the sequencer idle. A bypass result goes straight to S_OUT;
// a curve result passes the divider and curve states first. Stalls hold S_OUT.
// One item at a time; s_axis_tready is high only when the sequencer is idle.
// Reset (rst_n low, async) loads register defaults and the default curve.
`timescale 1ns / 1ps

module laser_dose_curve_power_map_core
    import ldcpm_pkg::*;
#(
    parameter int MAX_POINTS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] point_index, [18:4] point_density, [33:19] point_light,
    // [49:34] speed, [65:50] programmed_speed, [71:66] zero
    input  logic [71:0] s_axis_tdata,
    // [0] command
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [6:0] power_byte, [7] zero
    output logic [7:0]  m_axis_tdata,
    // [0] bypass
    output logic        m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DIV  = 5'd1;
    localparam logic [4:0] S_RC   = 5'd2;
    localparam logic [4:0] S_LS   = 5'd3;
    localparam logic [4:0] S_LN   = 5'd4;
    localparam logic [4:0] S_EX0  = 5'd5;
    localparam logic [4:0] S_EX1  = 5'd6;
    localparam logic [4:0] S_EX2  = 5'd7;
    localparam logic [4:0] S_EX3  = 5'd8;
    localparam logic [4:0] S_EX4  = 5'd9;
    localparam logic [4:0] S_CV0  = 5'd10;
    localparam logic [4:0] S_CV1  = 5'd11;
    localparam logic [4:0] S_CV2  = 5'd12;
    localparam logic [4:0] S_CA   = 5'd13;
    localparam logic [4:0] S_SRCH = 5'd14;
    localparam logic [4:0] S_LO   = 5'd15;
    localparam logic [4:0] S_M1   = 5'd16;
    localparam logic [4:0] S_M2   = 5'd17;
    localparam logic [4:0] S_M3   = 5'd18;
    localparam logic [4:0] S_FN0  = 5'd19;
    localparam logic [4:0] S_FN1  = 5'd20;
    localparam logic [4:0] S_OUT  = 5'd21;

    localparam logic [1:0] R_LIGHT = 2'd0;
    localparam logic [1:0] R_RATIO = 2'd1;
    localparam logic [1:0] R_POWER = 2'd2;

    logic [15:0] smin_reg, smax_reg;
    logic [6:0]  vmin_reg, vmax_reg;
    logic [10:0] gamma_reg;
    logic [3:0]  pcount_reg;

    point_t cd_reg [MAX_POINTS];
    point_t cl_reg [MAX_POINTS];

    logic [4:0]  state_reg;
    logic [1:0]  ret_reg;
    logic [4:0]  cnt_reg;
    logic [47:0] rem_reg, dv_reg;
    logic [15:0] q_reg;
    logic [15:0] speed_reg, prog_reg;
    logic [5:0]  n_reg;
    logic [16:0] light_reg;
    logic [30:0] y_reg;
    logic [3:0]  m_reg;
    logic [15:0] frac_reg;
    logic signed [8:0] ip_reg;
    logic [15:0] fp_reg;
    logic [22:0] lc_reg;
    logic [IW-1:0] i_reg;
    logic [22:0] hi_reg, b_reg, a_reg;
    point_t      dhi_reg, dlo_reg;
    logic [38:0] nn_reg;
    logic [22:0] mm_reg;
    logic [6:0]  res_pow_reg;
    logic        res_byp_reg;
    logic        out_valid_reg;
    logic [6:0]  out_pow_reg;
    logic        out_byp_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;

    logic [3:0]  in_idx;
    point_t      in_dens, in_light;
    logic [15:0] in_speed, in_prog;
    logic        in_acc;

    assign in_idx   = s_axis_tdata[3:0];
    assign in_dens  = s_axis_tdata[18:4];
    assign in_light = s_axis_tdata[33:19];
    assign in_speed = s_axis_tdata[49:34];
    assign in_prog  = s_axis_tdata[65:50];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_pow_reg};
    assign m_axis_tuser  = out_byp_reg;

    function automatic logic [3:0] msb16(logic [15:0] v);
        logic [3:0] p;
        p = 4'd0;
        for (int k = 0; k < 16; k++)
        begin
            if (v[k])
            begin
                p = 4'(k);
            end
        end
        return p;
    endfunction

    // table read port
    logic [IW-1:0] rd_idx;
    point_t        rd_d, rd_l;

    always_comb
    begin
        case (state_reg)
            S_SRCH:  rd_idx = i_reg;
            S_LO:    rd_idx = i_reg - IW'(1);
            default: rd_idx = '0;
        endcase
    end

    assign rd_d = cd_reg[rd_idx];
    assign rd_l = cl_reg[rd_idx];

    // derived values
    logic signed [11:0] gexp;
    logic signed [20:0] lg;
    logic [16:0] mant;
    logic signed [8:0] shamt;
    logic [33:0] tsh;
    logic [16:0] roll_light;
    logic [31:0] y2;
    logic        div_ge;
    logic [15:0] q_new;
    logic [7:0]  pq;
    logic [6:0]  pclamp;
    logic [15:0] progc;
    logic        roll_en;
    logic [5:0]  n_in;
    logic        in_byp;
    logic [15:0] in_diff, in_span;
    logic [22:0] lo_v, a_v;

    always_comb
    begin
        gexp   = $signed({1'b0, gamma_reg}) - 12'sd256;
        lg     = $signed({5'({1'b0, m_reg}) - 5'd16, frac_reg});
        mant   = LIGHT_ONE + 17'(prod_reg[31:16]);
        shamt  = 9'sd16 - ip_reg;
        tsh    = prod_reg[33:0] >> $unsigned(shamt[5:0]);
        if ($unsigned(shamt) >= 9'd34)
        begin
            roll_light = 17'd0;
        end
        else if (tsh > 34'(LIGHT_ONE))
        begin
            roll_light = LIGHT_ONE;
        end
        else
        begin
            roll_light = tsh[16:0];
        end
        y2     = prod_reg[61:30];
        div_ge = (rem_reg >= dv_reg);
        q_new  = {q_reg[14:0], div_ge};
        pq     = q_new[POWER_QW-1:0];
        pclamp = (pq > {1'b0, vmax_reg}) ? vmax_reg : pq[6:0];
        if (pclamp < vmin_reg)
        begin
            pclamp = vmin_reg;
        end
        progc   = (prog_reg > smax_reg) ? smax_reg : prog_reg;
        roll_en = (gamma_reg != GAMMA_UNITY) && (progc != 16'd0) && (speed_reg < progc);
        n_in    = ({2'b00, pcount_reg} > 6'(MAX_POINTS)) ? 6'(MAX_POINTS)
                                                        : {2'b00, pcount_reg};
        in_byp  = (n_in == 6'd0) || (in_speed <= smin_reg) || (smax_reg <= smin_reg);
        in_diff = in_speed - smin_reg;
        in_span = smax_reg - smin_reg;
        lo_v    = {rd_l, 8'd0};
        a_v     = lc_reg - lo_v;
        if (a_v > hi_reg - lo_v)
        begin
            a_v = hi_reg - lo_v;
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_LS:
            begin
                mul_a = $signed(33'(y_reg));
                mul_b = $signed(33'(y_reg));
            end
            S_EX0:
            begin
                mul_a = 33'(lg);
                mul_b = 33'(gexp);
            end
            S_EX1:
            begin
                mul_a = 33'sd22511;
                mul_b = $signed(33'(prod_reg[23:8]));
            end
            S_EX2:
            begin
                mul_a = $signed(33'(fp_reg));
                mul_b = $signed(33'(17'd43025 + 17'(prod_reg[31:16])));
            end
            S_EX3:
            begin
                mul_a = $signed(33'(light_reg));
                mul_b = $signed(33'(mant));
            end
            S_CV0:
            begin
                mul_a = $signed(33'(light_reg));
                mul_b = 33'sd100;
            end
            S_CV2:
            begin
                mul_a = $signed(33'(rd_d));
                mul_b = $signed(33'(lc_reg));
            end
            S_M1:
            begin
                mul_a = $signed(33'(dlo_reg));
                mul_b = $signed(33'(b_reg - a_reg));
            end
            S_M2:
            begin
                mul_a = $signed(33'(dhi_reg));
                mul_b = $signed(33'(a_reg));
            end
            S_FN0:
            begin
                mul_a = $signed(33'(mm_reg));
                mul_b = 33'sd25600;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // configuration and curve table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smin_reg   <= 16'd0;
            smax_reg   <= 16'd1000;
            vmin_reg   <= 7'd13;
            vmax_reg   <= 7'd127;
            gamma_reg  <= 11'd512;
            pcount_reg <= 4'd7;
            for (int k = 0; k < MAX_POINTS; k++)
            begin
                cd_reg[k] <= dflt_density(k);
                cl_reg[k] <= dflt_light(k);
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SPEED_MIN:   smin_reg   <= cfg_data;
                    REG_SPEED_MAX:   smax_reg   <= cfg_data;
                    REG_VALUE_MIN:   vmin_reg   <= cfg_data[6:0];
                    REG_VALUE_MAX:   vmax_reg   <= cfg_data[6:0];
                    REG_GAMMA:       gamma_reg  <= cfg_data[10:0];
                    REG_POINT_COUNT: pcount_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (in_acc && (s_axis_tuser == CMD_WRITE) &&
                ({2'b00, in_idx} < 6'(MAX_POINTS)))
            begin
                cd_reg[IW'(in_idx)] <= in_dens;
                cl_reg[IW'(in_idx)] <= in_light;
            end
        end
    end

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= R_LIGHT;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_OUT) && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && (s_axis_tuser == CMD_COMPUTE))
                    begin
                        if (in_byp)
                        begin
                            state_reg <= S_OUT;
                        end
                        else if (in_diff >= in_span)
                        begin
                            state_reg <= S_RC;
                        end
                        else
                        begin
                            ret_reg   <= R_LIGHT;
                            cnt_reg   <= 5'd16;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    if ((cnt_reg == 5'd1) && (ret_reg == R_RATIO) && (q_new != 16'd0))
                    begin
                        cnt_reg <= 5'd16;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 5'd1;
                    end
                    if (cnt_reg == 5'd1)
                    begin
                        case (ret_reg)
                            R_LIGHT: state_reg <= S_RC;
                            R_RATIO: state_reg <= (q_new == 16'd0) ? S_CV0 : S_LS;
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_RC:
                begin
                    if (roll_en)
                    begin
                        ret_reg   <= R_RATIO;
                        cnt_reg   <= 5'd16;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_CV0;
                    end
                end
                S_LS: state_reg <= S_LN;
                S_LN:
                begin
                    cnt_reg   <= cnt_reg - 5'd1;
                    state_reg <= (cnt_reg == 5'd1) ? S_EX0 : S_LS;
                end
                S_EX0: state_reg <= S_EX1;
                S_EX1: state_reg <= S_EX2;
                S_EX2: state_reg <= S_EX3;
                S_EX3: state_reg <= S_EX4;
                S_EX4: state_reg <= S_CV0;
                S_CV0: state_reg <= S_CV1;
                S_CV1: state_reg <= S_CV2;
                S_CV2:
                begin
                    if (lc_reg <= {rd_l, 8'd0})
                    begin
                        state_reg <= (rd_l == 15'd0) ? S_FN0 : S_CA;
                    end
                    else if (n_reg < 6'd2)
                    begin
                        state_reg <= S_FN0;
                    end
                    else
                    begin
                        state_reg <= S_SRCH;
                    end
                end
                S_CA: state_reg <= S_FN0;
                S_SRCH:
                begin
                    if (!((6'(i_reg) < n_reg - 6'd1) && (lc_reg > {rd_l, 8'd0})))
                    begin
                        state_reg <= S_LO;
                    end
                end
                S_LO: state_reg <= (hi_reg <= lo_v) ? S_FN0 : S_M1;
                S_M1: state_reg <= S_M2;
                S_M2: state_reg <= S_M3;
                S_M3: state_reg <= S_FN0;
                S_FN0: state_reg <= S_FN1;
                S_FN1:
                begin
                    ret_reg   <= R_POWER;
                    cnt_reg   <= 5'(POWER_QW);
                    state_reg <= S_DIV;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                speed_reg <= in_speed;
                prog_reg  <= in_prog;
                n_reg     <= n_in;
                light_reg <= LIGHT_ONE;
                rem_reg   <= 48'({in_diff, 16'd0});
                dv_reg    <= 48'(in_span) << 15;
                res_pow_reg <= 7'd0;
                res_byp_reg <= 1'b1;
            end
            S_DIV:
            begin
                if (div_ge)
                begin
                    rem_reg <= rem_reg - dv_reg;
                end
                dv_reg <= dv_reg >> 1;
                q_reg  <= q_new;
                if (cnt_reg == 5'd1)
                begin
                    case (ret_reg)
                        R_LIGHT: light_reg <= {1'b0, q_new};
                        R_RATIO:
                        begin
                            if (q_new == 16'd0)
                            begin
                                light_reg <= (gexp > 12'sd0) ? 17'd0 : LIGHT_ONE;
                            end
                            m_reg    <= msb16(q_new);
                            y_reg    <= 31'(q_new) << (5'd30 - 5'(msb16(q_new)));
                            frac_reg <= 16'd0;
                        end
                        default:
                        begin
                            res_pow_reg <= pclamp;
                            res_byp_reg <= 1'b0;
                        end
                    endcase
                end
            end
            S_RC:
            begin
                rem_reg <= 48'({speed_reg, 16'd0});
                dv_reg  <= 48'(progc) << 15;
            end
            S_LN:
            begin
                if (y2[31])
                begin
                    y_reg    <= y2[31:1];
                    frac_reg <= {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    y_reg    <= y2[30:0];
                    frac_reg <= {frac_reg[14:0], 1'b0};
                end
            end
            S_EX1:
            begin
                ip_reg <= $signed(prod_reg[32:24]);
                fp_reg <= prod_reg[23:8];
            end
            S_EX4: light_reg <= roll_light;
            S_CV1:
            begin
                lc_reg <= prod_reg[22:0];
                i_reg  <= IW'(1);
            end
            S_CV2:
            begin
                nn_reg <= 39'(rd_d);
                if ((lc_reg <= {rd_l, 8'd0}) && (rd_l != 15'd0))
                begin
                    mm_reg <= {rd_l, 8'd0};
                end
                else
                begin
                    mm_reg <= 23'd1;
                end
            end
            S_CA: nn_reg <= prod_reg[38:0];
            S_SRCH:
            begin
                if ((6'(i_reg) < n_reg - 6'd1) && (lc_reg > {rd_l, 8'd0}))
                begin
                    i_reg <= i_reg + IW'(1);
                end
                else
                begin
                    hi_reg  <= {rd_l, 8'd0};
                    dhi_reg <= rd_d;
                end
            end
            S_LO:
            begin
                nn_reg  <= 39'(rd_d);
                mm_reg  <= 23'd1;
                dlo_reg <= rd_d;
                b_reg   <= hi_reg - lo_v;
                a_reg   <= a_v;
            end
            S_M2: nn_reg <= prod_reg[38:0];
            S_M3:
            begin
                nn_reg <= nn_reg + prod_reg[38:0];
                mm_reg <= b_reg;
            end
            S_FN1:
            begin
                rem_reg <= 48'(nn_reg) * 48'(2 * POWER_PERIOD) + 48'(prod_reg[37:0]);
                dv_reg  <= 48'(prod_reg[37:0]) << 8;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_OUT) && (!out_valid_reg || m_axis_tready))
        begin
            out_pow_reg <= res_pow_reg;
            out_byp_reg <= res_byp_reg;
        end
    end

endmodule

>>> hdl/ldcpm_checker.sv
// Port-level checker for laser_dose_curve_power_map_core, with its bind.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module ldcpm_assert
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [71:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tuser
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // bypass beats carry power zero
    a_bypass_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0)
        else $error("bypass beat with nonzero power");

    // compute beat makes the block busy
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("ready right after compute beat");

    // point writes leave the block ready
    a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
        else $error("not ready after point write");

endmodule

bind laser_dose_curve_power_map_core ldcpm_assert u_ldcpm_assert (.*);

>>> tb/ldcpm_checker.sv
// Scoreboard for the laser dose curve power map core: tracks register and
// curve table writes, predicts each power beat and compares it. Uses ldcpm_pkg.
`timescale 1ns / 1ps

module ldcpm_checker
    import ldcpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending
);

    localparam int TABLE_DEPTH = 12;
    localparam longint unsigned ONE = 64'd1 << FRACTION_BITS;

    typedef struct packed {
        logic [6:0] power;
        logic       bypass;
    } power_beat_t;

    power_beat_t power_q[$];

    logic [15:0] speed_min, speed_max;
    logic [6:0]  value_min, value_max;
    logic [10:0] gamma;
    logic [3:0]  point_count;
    point_t      curve_density [TABLE_DEPTH];
    point_t      curve_light [TABLE_DEPTH];

    assign pending = power_q.size();

    function automatic longint fdiv(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q--;
        return q;
    endfunction

    function automatic longint log2_ratio(longint unsigned r);
        int m;
        int b;
        longint unsigned y;
        longint frac;
        m = 0;
        frac = 0;
        while ((r >> (m + 1)) != 0)
            m++;
        y = r << (30 - m);
        for (b = 15; b >= 0; b--) begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30)) begin
                y = y >> 1;
                frac = frac | (64'sd1 << b);
            end
        end
        return (longint'(m) - FRACTION_BITS) * 65536 + frac;
    endfunction

    function automatic longint unsigned bend_light(longint unsigned light,
                                                   longint unsigned ratio);
        longint gexp, e, ip, fp, k;
        longint unsigned fpu, mant, t;
        gexp = longint'(gamma) - 256;
        if (ratio == 0)
            return (gexp > 0) ? 64'd0 : ONE;
        e = fdiv(log2_ratio(ratio) * gexp, 256);
        ip = fdiv(e, 65536);
        fp = e - ip * 65536;
        fpu = fp;
        mant = 65536 + ((fpu * (43025 + ((22511 * fpu) >> 16))) >> 16);
        t = light * mant;
        k = ip - 16;
        if (k >= 0) begin
            if (t == 0)
                return 0;
            if (k > 40 || t > (ONE >> k))
                return ONE;
            return t << k;
        end
        if (-k >= 64)
            return 0;
        t = t >> (-k);
        return (t > ONE) ? ONE : t;
    endfunction

    function automatic longint unsigned dose_power(longint unsigned light, int n);
        longint unsigned lc, num, den, lo, hi, a, b, d0, l0;
        int i;
        lc = (light * 25600) >> (FRACTION_BITS - 8);
        d0 = curve_density[0];
        l0 = curve_light[0];
        if (lc <= (l0 << 8)) begin
            if (l0 == 0) begin
                num = d0 * POWER_PERIOD;
                den = 25600;
            end else begin
                num = d0 * lc * POWER_PERIOD;
                den = l0 * 256 * 25600;
            end
        end else if (n < 2) begin
            num = d0 * POWER_PERIOD;
            den = 25600;
        end else begin
            i = 1;
            while (i < n - 1 && lc > (longint'(curve_light[i]) << 8))
                i++;
            lo = longint'(curve_light[i-1]) << 8;
            hi = longint'(curve_light[i]) << 8;
            if (hi <= lo) begin
                num = longint'(curve_density[i-1]) * POWER_PERIOD;
                den = 25600;
            end else begin
                b = hi - lo;
                a = lc - lo;
                if (a > b)
                    a = b;
                num = (longint'(curve_density[i-1]) * (b - a) +
                       longint'(curve_density[i]) * a) * POWER_PERIOD;
                den = b * 25600;
            end
        end
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic power_beat_t map_speed(longint unsigned speed,
                                              longint unsigned prog);
        power_beat_t r;
        longint unsigned light, v;
        int n;
        n = (point_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(point_count);
        if (n == 0 || speed <= speed_min || speed_max <= speed_min) begin
            r.power = '0;
            r.bypass = 1'b1;
            return r;
        end
        light = ((speed - speed_min) << FRACTION_BITS) / (speed_max - speed_min);
        if (light > ONE)
            light = ONE;
        if (gamma != GAMMA_UNITY) begin
            if (prog > speed_max)
                prog = speed_max;
            if (prog > 0 && speed < prog)
                light = bend_light(light, (speed << FRACTION_BITS) / prog);
        end
        v = dose_power(light, n);
        if (v > value_max)
            v = value_max;
        if (v < value_min)
            v = value_min;
        r.power = v[6:0];
        r.bypass = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        power_beat_t got, want;
        if (!rst_n) begin
            speed_min <= 16'd0;
            speed_max <= 16'd1000;
            value_min <= 7'd13;
            value_max <= 7'd127;
            gamma <= 11'd512;
            point_count <= 4'd7;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                curve_density[i] <= dflt_density(i);
                curve_light[i] <= dflt_light(i);
            end
            power_q.delete();
            errors <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SPEED_MIN:   speed_min <= cfg_data;
                    REG_SPEED_MAX:   speed_max <= cfg_data;
                    REG_VALUE_MIN:   value_min <= cfg_data[6:0];
                    REG_VALUE_MAX:   value_max <= cfg_data[6:0];
                    REG_GAMMA:       gamma <= cfg_data[10:0];
                    REG_POINT_COUNT: point_count <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == CMD_WRITE) begin
                    if (s_axis_tdata[3:0] < TABLE_DEPTH) begin
                        curve_density[s_axis_tdata[3:0]] <= s_axis_tdata[18:4];
                        curve_light[s_axis_tdata[3:0]] <= s_axis_tdata[33:19];
                    end
                end else begin
                    power_q.push_back(map_speed(s_axis_tdata[49:34],
                                                s_axis_tdata[65:50]));
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.power = m_axis_tdata[6:0];
                got.bypass = m_axis_tuser;
                if (power_q.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual power %0d bypass %0d",
                             $time, got.power, got.bypass);
                    errors <= errors + 1;
                end else begin
                    want = power_q.pop_front();
                    if (got.power !== want.power || got.bypass !== want.bypass
                        || m_axis_tdata[7] !== 1'b0) begin
                        $display("%0t: mismatch, expected power %0d bypass %0d, actual power %0d bypass %0d",
                                 $time, want.power, want.bypass, got.power, got.bypass);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

>>> tb/tb.sv
// Top testbench for laser_dose_curve_power_map_core: drives curve writes,
// speed beats and register writes with random idling. Uses ldcpm_checker.
`timescale 1ns / 1ps

module tb;
    import ldcpm_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int          errors, pending;
    bit          quiet = 0;
    int          stall = 0;
    int          n_beats = 0;
    int          n_phases = 0;
    logic [15:0] cur_min = 16'd0, cur_max = 16'd1000;

    always #1 clk = ~clk;

    laser_dose_curve_power_map_core uut (.*);

    ldcpm_checker chk (.*);

    always @(posedge clk) begin
        if (quiet || !rst_n) begin
            m_axis_tready <= 1'b1;
        end else if (stall > 0) begin
            stall <= stall - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall <= $urandom_range(1, 10) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic send(logic cmd, logic [3:0] idx, logic [14:0] dens,
                        logic [14:0] lt, logic [15:0] spd, logic [15:0] prog);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {6'd0, prog, spd, lt, dens, idx};
        do @(posedge clk); while (!s_axis_tready);
        n_beats++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_SPEED_MIN) cur_min = val;
        if (idx == REG_SPEED_MAX) cur_max = val;
    endtask

    task automatic configure(logic [15:0] smin, logic [15:0] smax, logic [6:0] vmin,
                             logic [6:0] vmax, logic [10:0] g, logic [3:0] cnt);
        drain();
        reg_write(REG_SPEED_MIN, smin);
        reg_write(REG_SPEED_MAX, smax);
        reg_write(REG_VALUE_MIN, {9'd0, vmin});
        reg_write(REG_VALUE_MAX, {9'd0, vmax});
        reg_write(REG_GAMMA, {5'd0, g});
        reg_write(REG_POINT_COUNT, {12'd0, cnt});
        n_phases++;
    endtask

    task automatic load_curve(int n);
        int d, l;
        d = 0;
        l = 0;
        for (int i = 0; i < n; i++) begin
            d += $urandom_range(0, 25600 / n);
            l += $urandom_range((i == 0) ? 0 : 1, 25600 / n);
            send(CMD_WRITE, i[3:0], d[14:0], l[14:0], 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic random_speed();
        logic [15:0] spd, prog, lo, hi;
        lo = (cur_min < cur_max) ? cur_min : cur_max;
        hi = (cur_min < cur_max) ? cur_max : cur_min;
        case ($urandom_range(0, 3))
            0: spd = 16'($urandom);
            1: spd = 16'($urandom_range(lo, hi));
            2: spd = lo + 16'($urandom_range(0, 3));
            default: spd = 16'($urandom_range(lo, (hi > 65000) ? 16'hffff : hi + 500));
        endcase
        case ($urandom_range(0, 3))
            0: prog = 16'($urandom);
            1: prog = 16'(spd + $urandom_range(0, 2000));
            2: prog = 16'($urandom_range(0, 2));
            default: prog = hi;
        endcase
        send(CMD_COMPUTE, 4'($urandom), 15'($urandom), 15'($urandom), spd, prog);
    endtask

    task automatic random_run(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0)
                send(CMD_WRITE, 4'($urandom), 15'($urandom), 15'($urandom),
                     16'($urandom), 16'($urandom));
            else
                random_speed();
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset curve and registers, then point writes and corner register settings
        send(CMD_COMPUTE, 4'd0, 15'd0, 15'd0, 16'd0, 16'd0);
        send(CMD_COMPUTE, 4'd0, 15'd0, 15'd0, 16'd1000, 16'd1000);
        send(CMD_COMPUTE, 4'd0, 15'd0, 15'd0, 16'd500, 16'd1000);
        send(CMD_COMPUTE, 4'd0, 15'd0, 15'd0, 16'd1, 16'd65535);
        send(CMD_COMPUTE, 4'd0, 15'd0, 15'd0, 16'hffff, 16'hffff);
        send(CMD_COMPUTE, 4'd0, 15'd0, 15'd0, 16'd300, 16'd0);
        send(CMD_COMPUTE, 4'd0, 15'd0, 15'd0, 16'd5, 16'd900);
        send(CMD_WRITE, 4'd15, 15'h7fff, 15'h7fff, 16'd0, 16'd0);
        send(CMD_WRITE, 4'd12, 15'h7fff, 15'h7fff, 16'd0, 16'd0);
        send(CMD_COMPUTE, 4'd0, 15'd0, 15'd0, 16'd999, 16'd1000);
        send(CMD_WRITE, 4'd0, 15'd3000, 15'd0, 16'd0, 16'd0);
        send(CMD_COMPUTE, 4'd0, 15'd0, 15'd0, 16'd1, 16'd0);
        send(CMD_WRITE, 4'd2, 15'd9000, 15'd200, 16'd0, 16'd0);
        send(CMD_COMPUTE, 4'd0, 15'd0, 15'd0, 16'd40, 16'd0);
        send(CMD_WRITE, 4'd11, 15'h7fff, 15'h7fff, 16'hffff, 16'hffff);
        configure(16'd0, 16'd1000, 7'd100, 7'd20, 11'd64, 4'd1);
        send(CMD_COMPUTE, 4'd0, 15'd0, 15'd0, 16'd900, 16'd0);
        send(CMD_COMPUTE, 4'd0, 15'd0, 15'd0, 16'd2, 16'd1000);
        configure(16'd500, 16'd200, 7'd0, 7'd127, 11'd256, 4'd0);
        send(CMD_COMPUTE, 4'd0, 15'd0, 15'd0, 16'd600, 16'd0);
        configure(16'd0, 16'd1000, 7'd0, 7'd127, 11'd256, 4'd15);
        send(CMD_COMPUTE, 4'd0, 15'd0, 15'd0, 16'd700, 16'd900);

        configure(16'd0, 16'd1000, 7'd13, 7'd127, 11'd512, 4'd7);
        load_curve(7);
        random_run(130);
        drain();

        configure(16'd100, 16'd5000, 7'd0, 7'd127, 11'd1024, 4'd12);
        load_curve(12);
        random_run(130);

        configure(16'd0, 16'hffff, 7'd127, 7'd0, 11'h7ff, 4'd2);
        load_curve(2);
        random_run(100);

        configure(16'hffff, 16'd0, 7'h7f, 7'h7f, 11'd0, 4'd3);
        random_run(30);

        configure(16'($urandom_range(0, 3000)), 16'($urandom_range(4000, 60000)),
                  7'($urandom_range(0, 30)), 7'($urandom_range(90, 127)),
                  11'($urandom_range(64, 1024)), 4'($urandom_range(3, 12)));
        load_curve(12);
        random_run(130);

        configure(16'd1000, 16'd3000, 7'd1, 7'd126, 11'd300, 4'd5);
        load_curve(5);
        random_run(150);

        configure(16'd0, 16'd2000, 7'd5, 7'd120, 11'd200, 4'd9);
        load_curve(9);
        quiet = 1;
        random_run(120);
        drain();

        $display("Covered %0d input beats over %0d register settings,", n_beats, n_phases);
        $display("with curve loads, bypass cases, rolloff and crossed limits.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> laser_dose_curve_power_map_core.f
hdl/ldcpm_pkg.sv
hdl/laser_dose_curve_power_map_core.sv
hdl/ldcpm_checker.sv
tb/ldcpm_checker.sv
tb/tb.sv
